[rtl/core/tmf_pkg.sv]
// ----------------------------------------------------------------------------
// tmf_pkg
// Shared constants, status codes and the controller command type for the
// toggle-membership byte queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tmf_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_DEQUEUE = 1'b1;

  typedef enum logic [2:0] {
    ST_DEQUEUED = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_APPENDED = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic load;     // execute the input item and capture its result
  } tmf_cmd_t;

endpackage

`default_nettype wire

[rtl/core/toggle_membership_fifo_core.sv]
// ----------------------------------------------------------------------------
// toggle_membership_fifo_core
// Order-keeping byte queue in which each byte is present at most once.
//
// Input channel s_*: tuser = mode (0 insert/toggle, 1 dequeue),
//   tdata = byte_value. An insert removes the byte if it is stored (later
//   entries close the gap in order), otherwise appends it, or reports full.
// Output channel m_*: one result transfer per input transfer.
//   tuser = status, tdata = {count_after, out_byte}.
// Latency: the result is valid the cycle after the input transfer.
// One item in flight: the single result register must be taken before the
//   controller accepts the next input transfer.
// Compare and compaction over all DEPTH entries happen in parallel in a
//   row of entry cells.
// Reset: rst (synchronous) empties the queue and drops any pending result;
//   no clearing pass is needed.
// Stall: while m_tready is low the result holds and s_tready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module toggle_membership_fifo_core
  import tmf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
  input  wire logic        s_tuser,   // [0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] out_byte, [12:8] count_after, [15:13] zero
  output logic [2:0]       m_tuser    // [2:0] status
);

  tmf_cmd_t   cmd;
  status_t    status;
  logic [7:0] out_byte;
  logic [4:0] count_after;

  tmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  tmf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .mode        (s_tuser),
    .byte_value  (s_tdata),
    .status      (status),
    .out_byte    (out_byte),
    .count_after (count_after)
  );

  assign m_tdata = {3'b000, count_after, out_byte};
  assign m_tuser = status;

endmodule

`default_nettype wire

[rtl/core/tmf_ctrl.sv]
// ----------------------------------------------------------------------------
// tmf_ctrl
// Handshake controller: takes one transfer, holds the result until the
// downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tmf_ctrl
  import tmf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output tmf_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_OUT
  } state_t;

  state_t state;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign cmd.load = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/tmf_datapath.sv]
// ----------------------------------------------------------------------------
// tmf_datapath
// Row of entry cells with parallel compare and shift-up compaction, plus the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tmf_datapath
  import tmf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire tmf_cmd_t   cmd,
  input  wire logic       mode,
  input  wire logic [7:0] byte_value,
  output status_t         status,
  output logic [7:0]      out_byte,
  output logic [4:0]      count_after
);

  logic [7:0]       entries [DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic [DEPTH-1:0] match;
  logic [DEPTH-1:0] shift;
  logic             found;
  logic             do_shift;
  logic             do_append;
  status_t          status_next;
  logic [7:0]       byte_next;
  logic [31:0]      count_wide;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (mode == MODE_INSERT) && (CNT_W'(i) < count) && (entries[i] == byte_value);
    end
  end

  assign found = |match;

  // Cell i moves up when a match sits at or below it; a dequeue shifts all.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      shift[i] = (mode == MODE_DEQUEUE) || (|(match << (DEPTH - 1 - i)));
    end
  end

  always_comb begin
    do_shift    = 1'b0;
    do_append   = 1'b0;
    count_next  = count;
    status_next = ST_EMPTY;
    byte_next   = byte_value;
    if (mode == MODE_DEQUEUE) begin
      if (count == '0) begin
        status_next = ST_EMPTY;
        byte_next   = 8'd0;
      end else begin
        do_shift    = 1'b1;
        status_next = ST_DEQUEUED;
        byte_next   = entries[0];
        count_next  = count - 1'b1;
      end
    end else if (found) begin
      do_shift    = 1'b1;
      status_next = ST_REMOVED;
      count_next  = count - 1'b1;
    end else if (count == CNT_W'(DEPTH)) begin
      status_next = ST_FULL;
    end else begin
      do_append   = 1'b1;
      status_next = ST_APPENDED;
      count_next  = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (do_shift && shift[i] && (i < DEPTH - 1)) begin
          entries[i] <= entries[(i < DEPTH - 1) ? i + 1 : i];
        end else if (do_append && (count == CNT_W'(i))) begin
          entries[i] <= byte_value;
        end
      end
    end
  end

  assign count_wide = 32'(count_next);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status      <= status_next;
      out_byte    <= byte_next;
      count_after <= count_wide[4:0];
    end
  end

endmodule

`default_nettype wire

[rtl/core/tmf_checker.sv]
// ----------------------------------------------------------------------------
// tmf_checker
// Port-level assertions for the toggle-membership byte queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tmf_checker
  import tmf_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input accepted while a result is pending");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("no result after an input transfer");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= 3'd4) && (m_tdata[12:8] <= 5'(DEPTH)))
    else $error("bad status or count");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed under stall");

endmodule

bind toggle_membership_fifo_core tmf_checker u_tmf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[tb/tb_toggle_membership_fifo_core.sv]
// ----------------------------------------------------------------------------
// tb_toggle_membership_fifo_core
// Self-checking bench for the toggle-membership byte queue. A clocked driver
// feeds queued insert/dequeue items with random idle bursts. A clocked
// monitor takes results under random backpressure and compares each one
// against an in-bench copy of the queue contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_toggle_membership_fifo_core;
  import tmf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 500;
  localparam int QUIET_TAIL  = 60;   // no idling for the last items

  typedef struct {
    logic       mode;
    logic [7:0] val;
    bit         drain;   // hold off until every result is back
  } req_t;

  typedef struct {
    status_t    st;
    logic [7:0] data;
    logic [4:0] cnt;
  } resp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] byte_value
  logic        s_tuser = 1'b0;    // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;           // [7:0] out_byte, [12:8] count_after
  logic [2:0]  m_tuser;           // [2:0] status

  req_t  pending_reqs[$];
  resp_t expected_resps[$];

  // bench copy of the queue, oldest at index 0
  logic [7:0] q_bytes[DEPTH];
  int         q_len = 0;

  int unsigned sent_cnt = 0;
  int unsigned got_cnt  = 0;
  int          errors   = 0;
  int          cycles   = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  bit          quiet = 1'b0;

  toggle_membership_fifo_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  task automatic add_req(input logic mode, input logic [7:0] val, input bit drain);
    req_t r;
    r.mode  = mode;
    r.val   = val;
    r.drain = drain;
    pending_reqs.push_back(r);
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10)
      $display("%0t: %s", $realtime, msg);
  endtask

  // Apply one transfer to the bench copy and queue the result it must give.
  task automatic predict_result(input logic mode, input logic [7:0] val);
    resp_t e;
    int    kept;
    bit    found;
    kept  = 0;
    found = 1'b0;
    if (mode == MODE_DEQUEUE) begin
      if (q_len == 0) begin
        e.st   = ST_EMPTY;
        e.data = 8'h00;
      end else begin
        e.st   = ST_DEQUEUED;
        e.data = q_bytes[0];
        for (int i = 1; i < q_len; i++)
          q_bytes[i-1] = q_bytes[i];
        q_len--;
      end
    end else begin
      // close the gap behind any matching entry
      for (int i = 0; i < q_len; i++) begin
        if (q_bytes[i] == val) begin
          found = 1'b1;
        end else begin
          q_bytes[kept] = q_bytes[i];
          kept++;
        end
      end
      q_len  = kept;
      e.data = val;
      if (found) begin
        e.st = ST_REMOVED;
      end else if (q_len >= DEPTH) begin
        e.st = ST_FULL;
      end else begin
        q_bytes[q_len] = val;
        q_len++;
        e.st = ST_APPENDED;
      end
    end
    e.cnt = 5'(q_len);
    expected_resps.push_back(e);
  endtask

  // driver
  always @(posedge clk) begin
    logic        nxt_valid;
    int unsigned outstanding;
    req_t        r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      nxt_valid   = s_tvalid;
      outstanding = sent_cnt - got_cnt;
      if (s_tvalid && s_tready) begin
        predict_result(s_tuser, s_tdata);
        sent_cnt   <= sent_cnt + 1;
        outstanding = outstanding + 1;
        nxt_valid   = 1'b0;
        if (!quiet && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 19);
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && outstanding != 0)) begin
          r = pending_reqs.pop_front();
          s_tuser   <= r.mode;
          s_tdata   <= r.val;
          nxt_valid  = 1'b1;
          quiet     <= (pending_reqs.size() < QUIET_TAIL);
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  // result side backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0 && !quiet) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 19);
    end
  end

  // monitor
  always @(posedge clk) begin
    resp_t e;
    if (!rst && m_tvalid && m_tready) begin
      got_cnt <= got_cnt + 1;
      if (expected_resps.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d byte %02h count %0d",
                             m_tuser, m_tdata[7:0], m_tdata[12:8]));
      end else begin
        e = expected_resps.pop_front();
        if (m_tuser !== e.st || m_tdata[7:0] !== e.data || m_tdata[12:8] !== e.cnt)
          flag_error($sformatf(
            "mismatch: expected status %0d byte %02h count %0d, got %0d %02h %0d",
            e.st, e.data, e.cnt, m_tuser, m_tdata[7:0], m_tdata[12:8]));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_toggle_membership_fifo_core failed");
      $finish;
    end
  end

  initial begin
    int n;
    int plen;
    int ins_pct;
    int span;
    int phase;
    logic [7:0] base;
    logic [7:0] v;

    // directed: empty dequeue, byte extremes, toggle-off, fill to full,
    // drop when full, removal of a present byte when full, normal dequeue
    add_req(MODE_DEQUEUE, 8'h5A, 1'b0);
    add_req(MODE_INSERT, 8'h00, 1'b0);
    add_req(MODE_INSERT, 8'hFF, 1'b0);
    add_req(MODE_INSERT, 8'hFF, 1'b0);
    add_req(MODE_INSERT, 8'hFF, 1'b0);
    for (int k = 1; k <= DEPTH - 2; k++)
      add_req(MODE_INSERT, 8'(8'h10 + k * 8'h11), 1'b0);
    add_req(MODE_INSERT, 8'hAA, 1'b0);
    add_req(MODE_INSERT, 8'h00, 1'b0);
    add_req(MODE_DEQUEUE, 8'h00, 1'b0);

    // random phases, each with its own insert bias and byte pool
    n     = 0;
    phase = 0;
    while (n < RAND_ITEMS) begin
      plen    = $urandom_range(30, 70);
      ins_pct = $urandom_range(50, 95);
      span    = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(3, 47);
      base    = 8'($urandom_range(0, 255));
      for (int i = 0; i < plen && n < RAND_ITEMS; i++) begin
        v = 8'(base + $urandom_range(0, span));
        if (span == 255)
          v = 8'($urandom_range(0, 255));
        add_req(($urandom_range(1, 100) <= ins_pct) ? MODE_INSERT : MODE_DEQUEUE,
                v, (i == 0) && (phase % 3 == 0));
        n++;
      end
      phase++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_tvalid || sent_cnt != got_cnt)
      @(posedge clk);
    repeat (8) @(posedge clk);

    if (expected_resps.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_resps.size()));

    if (errors == 0)
      $display("tb_toggle_membership_fifo_core passed");
    else
      $display("tb_toggle_membership_fifo_core failed");
    $finish;
  end

endmodule
